/* hw/rtl/svpd_pkg.sv */
package svpd_pkg;

  localparam logic [7:0] HdrByte = 8'hFF;
  localparam logic [7:0] LowMask = 8'h7F;
  localparam logic [7:0] NegMark = 8'hF0;

  localparam int unsigned CountW = 5;
  localparam int unsigned ValueW = 16;
  localparam int unsigned OutIdxW = 4;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhLow  = 2'd1,
    PhHigh = 2'd2,
    PhSign = 2'd3
  } phase_e;

  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic [OutIdxW-1:0]       index;
    logic                     last;
  } result_t;

endpackage

/* hw/rtl/svpd_decode.sv */
module svpd_decode #(
  parameter int unsigned MAX_VALUES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   byte_i,
  input  logic [svpd_pkg::CountW-1:0]  count_i,
  output svpd_pkg::result_t            result_o
);

  localparam int unsigned IdxW  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int unsigned MaxW  = $clog2(MAX_VALUES + 1);
  localparam int unsigned CmpW  = ((MaxW > svpd_pkg::CountW) ? MaxW : svpd_pkg::CountW) + 1;

  localparam logic [CmpW-1:0] MaxCount = CmpW'(MAX_VALUES);

  svpd_pkg::phase_e phase_q, phase_d;
  logic [IdxW-1:0]  index_q, index_d;
  logic [6:0]       low_q, low_d;
  logic [7:0]       high_q, high_d;

  logic [CmpW-1:0]                    count_ext;
  logic [CmpW-1:0]                    eff_count;
  logic [CmpW-1:0]                    index_plus;
  logic                               last;
  logic [svpd_pkg::ValueW-1:0]        mag;
  logic [IdxW+svpd_pkg::OutIdxW-1:0]  index_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= svpd_pkg::PhHunt;
      index_q <= '0;
      low_q   <= '0;
      high_q  <= '0;
    end else begin
      phase_q <= phase_d;
      index_q <= index_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  // zero count acts as one, counts above the limit saturate
  always_comb begin
    count_ext = CmpW'(count_i);
    if (count_ext == '0) begin
      eff_count = CmpW'(1);
    end else if (count_ext > MaxCount) begin
      eff_count = MaxCount;
    end else begin
      eff_count = count_ext;
    end
  end

  assign index_plus = CmpW'(index_q) + CmpW'(1);
  assign last       = (index_plus >= eff_count);
  assign mag        = {1'b0, high_q, low_q};
  assign index_ext  = {{svpd_pkg::OutIdxW{1'b0}}, index_q};

  always_comb begin
    phase_d = phase_q;
    index_d = index_q;
    low_d   = low_q;
    high_d  = high_q;

    result_o.valid = 1'b0;
    result_o.value = (byte_i == svpd_pkg::NegMark) ? -mag : mag;
    result_o.index = index_ext[svpd_pkg::OutIdxW-1:0];
    result_o.last  = last;

    if (accept_i) begin
      unique case (phase_q)
        svpd_pkg::PhHunt: begin
          if (byte_i == svpd_pkg::HdrByte) begin
            phase_d = svpd_pkg::PhLow;
            index_d = '0;
          end
        end
        svpd_pkg::PhLow: begin
          low_d   = 7'(byte_i & svpd_pkg::LowMask);
          phase_d = svpd_pkg::PhHigh;
        end
        svpd_pkg::PhHigh: begin
          high_d  = byte_i;
          phase_d = svpd_pkg::PhSign;
        end
        svpd_pkg::PhSign: begin
          result_o.valid = 1'b1;
          low_d  = '0;
          high_d = '0;
          if (last) begin
            phase_d = svpd_pkg::PhHunt;
            index_d = '0;
          end else begin
            phase_d = svpd_pkg::PhLow;
            index_d = index_q + IdxW'(1);
          end
        end
        default: begin
          phase_d = svpd_pkg::PhHunt;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/signed_value_packet_deframer.sv */
// channel   dir  width  fields (low bit up)
// s_axis    in   8      rx_byte
// m_axis    out  24     value[15:0], value_index[19:16], zero fill; tlast = last_in_packet
// cfg       in   5      values_per_packet, written when cfg_we_i is high
//
// one byte is taken per cycle while s_axis_tready is high; a value leaves in the cycle after its sign byte
// is taken, set by the single result register behind the byte decoder.
// reset puts the decoder in header hunt with the count at one.
// a result held by m_axis_tready low stalls s_axis until it is taken;
// the register frees in the same cycle it is taken, so no bubble appears.
module signed_value_packet_deframer #(
  parameter int unsigned MAX_VALUES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // value[15:0], value_index[19:16], zeros
  output logic        m_axis_tlast,   // last_in_packet

  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i     // values_per_packet
);

  logic [svpd_pkg::CountW-1:0] count_q;
  logic                        accept;
  svpd_pkg::result_t           result;

  logic                              out_valid_q;
  logic [svpd_pkg::ValueW-1:0]       out_value_q;
  logic [svpd_pkg::OutIdxW-1:0]      out_index_q;
  logic                              out_last_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= svpd_pkg::CountW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  svpd_decode #(
    .MAX_VALUES(MAX_VALUES)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .count_i (count_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      out_value_q <= result.value;
      out_index_q <= result.index;
      out_last_q  <= result.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_index_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* test/signed_value_packet_deframer_tb.sv */
module signed_value_packet_deframer_tb;

  localparam int unsigned MaxValues = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PacketBytes = 1200;
  localparam int unsigned NumRows = 29;

  typedef struct packed {
    logic signed [svpd_pkg::ValueW-1:0] value;
    logic [svpd_pkg::OutIdxW-1:0]       index;
    logic                               last;
  } decoded_t;

  typedef enum logic {
    RowByte,
    RowCount
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;
    logic       typed;
    decoded_t   result;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    decoded_t   result;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;

  signed_value_packet_deframer #(
    .MAX_VALUES(MaxValues)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state as the byte stream should leave it
  svpd_pkg::phase_e pred_phase = svpd_pkg::PhHunt;
  int unsigned pred_index = 0;
  logic [6:0]  pred_low = '0;
  logic [7:0]  pred_high = '0;
  logic [4:0]  pred_count = 5'd1;

  rx_item_t    rx_pending[$];
  decoded_t    value_expect_q[$];
  rx_item_t    rx_cur;
  decoded_t    rx_res;
  decoded_t    want;
  bit          rx_made;
  int unsigned rx_queued = 0;
  int unsigned rx_taken = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 34;

  stim_row_t directed_rows [NumRows] = '{
    '{RowByte,  8'h00, 1'b0, '0},
    '{RowByte,  8'h7F, 1'b0, '0},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'hF0, 1'b1, '{-16'sd32767, 4'd0, 1'b1}},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'h80, 1'b0, '0},
    '{RowByte,  8'h00, 1'b0, '0},
    '{RowByte,  8'h00, 1'b1, '{16'sd0, 4'd0, 1'b1}},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'h7F, 1'b0, '0},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'hEF, 1'b1, '{16'sd32767, 4'd0, 1'b1}},
    '{RowCount, 8'h00, 1'b0, '0},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'h01, 1'b0, '0},
    '{RowByte,  8'h00, 1'b0, '0},
    '{RowByte,  8'hF0, 1'b1, '{-16'sd1, 4'd0, 1'b1}},
    '{RowCount, 8'h03, 1'b0, '0},
    '{RowByte,  8'hFF, 1'b0, '0},
    '{RowByte,  8'h05, 1'b0, '0},
    '{RowByte,  8'h02, 1'b0, '0},
    '{RowByte,  8'hF1, 1'b0, '0},
    // count drops to one in the middle of the packet
    '{RowCount, 8'h01, 1'b0, '0},
    '{RowByte,  8'h06, 1'b0, '0},
    '{RowByte,  8'h01, 1'b0, '0},
    '{RowByte,  8'hF0, 1'b1, '{-16'sd134, 4'd1, 1'b1}},
    '{RowCount, 8'h1F, 1'b0, '0}
  };

  function automatic bit decode_rx_byte(input logic [7:0] b, output decoded_t res);
    int unsigned eff;
    logic [15:0] mag;
    res = '0;
    decode_rx_byte = 1'b0;
    case (pred_phase)
      svpd_pkg::PhHunt: begin
        if (b == svpd_pkg::HdrByte) begin
          pred_phase = svpd_pkg::PhLow;
          pred_index = 0;
        end
      end
      svpd_pkg::PhLow: begin
        pred_low = 7'(b & svpd_pkg::LowMask);
        pred_phase = svpd_pkg::PhHigh;
      end
      svpd_pkg::PhHigh: begin
        pred_high = b;
        pred_phase = svpd_pkg::PhSign;
      end
      default: begin
        eff = (pred_count == 0) ? 1 : ((pred_count > MaxValues) ? MaxValues : pred_count);
        mag = {1'b0, pred_high, pred_low};
        res.value = (b == svpd_pkg::NegMark) ? -mag : mag;
        res.index = pred_index[svpd_pkg::OutIdxW-1:0];
        res.last = (pred_index + 1 >= eff);
        pred_low = '0;
        pred_high = '0;
        if (res.last) begin
          pred_phase = svpd_pkg::PhHunt;
          pred_index = 0;
        end else begin
          pred_phase = svpd_pkg::PhLow;
          pred_index++;
        end
        decode_rx_byte = 1'b1;
      end
    endcase
  endfunction

  function automatic void queue_rx(input logic [7:0] b, input logic typed, input decoded_t res);
    rx_pending.push_back('{b, typed, res});
    rx_queued++;
  endfunction

  function automatic logic [7:0] pick_data_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return svpd_pkg::HdrByte;
    if (r < 28) return 8'h00;
    if (r < 36) return 8'h80;
    if (r < 44) return svpd_pkg::NegMark;
    return 8'($urandom_range(255));
  endfunction

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while (rx_taken != rx_queued) @(posedge clk_i);
    while (value_expect_q.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] cnt);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred_count = cnt;
  endtask

  // byte sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rx_taken++;
        rx_made = decode_rx_byte(rx_cur.rx, rx_res);
        if (rx_cur.typed) begin
          value_expect_q.push_back(rx_cur.result);
        end else if (rx_made) begin
          value_expect_q.push_back(rx_res);
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          rx_cur = rx_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rx_cur.rx;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // value receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (value_expect_q.size() == 0) begin
          $error("unexpected value transfer, tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = value_expect_q.pop_front();
          if (m_axis_tdata[15:0] !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, $signed(m_axis_tdata[15:0]));
            fail_count++;
          end
          if (m_axis_tdata[19:16] !== want.index) begin
            $error("value_index: expected %0d, got %0d", want.index, m_axis_tdata[19:16]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_in_packet: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tdata[23:20] !== 4'h0) begin
            $error("tdata fill: expected 0, got %h", m_axis_tdata[23:20]);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("signed_value_packet_deframer_tb failed");
      $finish;
    end
  end

  initial begin
    logic [4:0]  counts [8];
    logic [4:0]  cnt;
    int unsigned packet_bytes;
    int unsigned phase_end;
    int unsigned phase_no;
    int unsigned eff;
    int unsigned roll;
    int unsigned cut;
    bit          broken;
    counts = '{5'd16, 5'd0, 5'd2, 5'd17, 5'd1, 5'd5, 5'd31, 5'd3};
    packet_bytes = 0;
    phase_no = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowCount) begin
        write_count(directed_rows[i].data[4:0]);
      end else begin
        queue_rx(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    while (packet_bytes < PacketBytes) begin
      cnt = (phase_no < 8) ? counts[phase_no] : 5'($urandom_range(31));
      write_count(cnt);
      eff = (cnt == 0) ? 1 : ((cnt > MaxValues) ? MaxValues : cnt);
      // one phase runs with both sides always ready
      idle_pct = (phase_no == 3) ? 0 : 34;
      phase_end = packet_bytes + 80 + $urandom_range(80) + ((phase_no == 3) ? 200 : 0);
      while (packet_bytes < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          repeat ($urandom_range(1, 4)) queue_rx(8'($urandom_range(255)), 1'b0, '0);
        end else begin
          broken = (roll < 16);
          cut = $urandom_range(3 * eff - 1);
          queue_rx(svpd_pkg::HdrByte, 1'b0, '0);
          packet_bytes++;
          for (int unsigned k = 0; k < 3 * eff; k++) begin
            if (broken && k == cut) break;
            if (k % 3 == 2 && $urandom_range(1)) begin
              queue_rx(svpd_pkg::NegMark, 1'b0, '0);
            end else begin
              queue_rx(pick_data_byte(), 1'b0, '0);
            end
            packet_bytes++;
          end
        end
      end
      phase_no++;
    end

    idle_pct = 34;
    wait_drained();
    if (value_expect_q.size() != 0) begin
      $error("values never delivered: %0d", value_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("signed_value_packet_deframer_tb passed");
    end else begin
      $display("signed_value_packet_deframer_tb failed");
    end
    $finish;
  end

endmodule
